FILE: rtl/core/assert_macros.svh
// Assertion macros for the RTL of the text extractor.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The antecedent implies the consequent in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// The antecedent implies the consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/core/ecte_pkg.sv
// Package with codes, constants and types of the escape-coded text extractor.
`timescale 1ns / 1ps

package ecte_pkg;

	localparam logic [1:0] MODE_NORMAL  = 2'd0;
	localparam logic [1:0] MODE_SKIP    = 2'd1;
	localparam logic [1:0] MODE_LITERAL = 2'd2;
	localparam logic [1:0] MODE_CONTROL = 2'd3;

	localparam logic [2:0] KIND_CHAR     = 3'd0;
	localparam logic [2:0] KIND_TAB      = 3'd1;
	localparam logic [2:0] KIND_NEWLINE  = 3'd2;
	localparam logic [2:0] KIND_NULL     = 3'd3;
	localparam logic [2:0] KIND_BAD_CTRL = 3'd4;
	localparam logic [2:0] KIND_BAD_CODE = 3'd5;

	localparam logic [7:0] BYTE_NULL      = 8'h00;
	localparam logic [7:0] BYTE_TOP       = 8'h80;
	localparam logic [7:0] CODE_SKIP2_LO  = 8'he5;
	localparam logic [7:0] CODE_SKIP2_HI  = 8'he8;
	localparam logic [7:0] CODE_SKIP1_LO  = 8'he9;
	localparam logic [7:0] CODE_SKIP1_HI  = 8'hec;
	localparam logic [7:0] CODE_SKIP3     = 8'hef;
	localparam logic [7:0] CODE_LITERAL   = 8'hc1;
	localparam logic [7:0] CODE_SKIP2_A   = 8'hc2;
	localparam logic [7:0] CODE_CONTROL   = 8'hc4;
	localparam logic [7:0] CODE_SKIP2_B   = 8'hc5;
	localparam logic [7:0] CODE_SKIP7     = 8'hf1;
	localparam logic [7:0] CTRL_TAB       = 8'h04;
	localparam logic [7:0] CTRL_SKIP2     = 8'h19;
	localparam logic [7:0] CTRL_SKIP6     = 8'h1b;
	localparam logic [7:0] CHAR_TAB       = 8'h09;
	localparam logic [7:0] CHAR_NEWLINE   = 8'h0a;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] char_value;
	} result_t;

	typedef struct packed {
		result_t first;
		result_t second;
		logic    two;
	} entry_t;

endpackage

FILE: rtl/core/escape_coded_text_extractor.sv
// Top level of the escape-coded text extractor.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Usage:
// The slave channel takes one byte of a paragraph text body per item:
// s_tdata holds the byte, s_tuser marks the first byte of a paragraph and
// s_tlast marks its last byte. The master channel gives one result per item:
// m_tdata holds the result kind and its character, and m_tlast is set on the
// last result that one input byte causes.
// Each byte is decoded in the cycle it is accepted, so the parse state is
// current for the next byte; its results go into the output register, or
// into the skid register while the output register is busy. A byte gives
// zero, one or two results. Throughput is one byte per cycle while each byte
// gives at most one result and the receiver is ready; a byte with two results
// (a character and the end-of-paragraph newline) holds the output register until both are taken.
// When the receiver stalls, the output register holds its entry and a
// one-entry skid register takes one more byte; s_tready then falls.
// Bytes that give no result never need buffer space.
// Reset clears the parse state and empties both registers.
module escape_coded_text_extractor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] run_start
	input  logic        s_tlast,   // run_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [2:0] kind, [10:3] char_value, [15:11] zero
	output logic        m_tlast    // final_res
);

	logic [1:0] mode_q;
	logic [2:0] skip_q;
	logic       main_v_q;
	logic       skid_v_q;
	logic       sel_q;
	ecte_pkg::entry_t main_q;
	ecte_pkg::entry_t skid_q;

	logic [1:0] mode_in;
	logic [2:0] skip_in;
	logic [1:0] mode_nx;
	logic [2:0] skip_nx;
	logic       has_res;
	ecte_pkg::result_t res0;
	ecte_pkg::result_t res_nl;
	ecte_pkg::entry_t  new_entry;
	logic       any_res;
	logic       accept;
	logic       store;
	logic       pop;
	logic       main_done;
	logic       main_free;
	logic       load_skid_main;
	logic       load_new_main;
	logic       load_skid;
	ecte_pkg::result_t cur;

	assign accept = s_tvalid && s_tready;
	assign mode_in = s_tuser ? ecte_pkg::MODE_NORMAL : mode_q;
	assign skip_in = s_tuser ? 3'd0 : skip_q;

	always_comb begin
		mode_nx = ecte_pkg::MODE_NORMAL;
		skip_nx = skip_in;
		has_res = 1'b0;
		res0.kind = ecte_pkg::KIND_CHAR;
		res0.char_value = s_tdata;
		case (mode_in)
			ecte_pkg::MODE_SKIP: begin
				skip_nx = (skip_in != 3'd0) ? skip_in - 3'd1 : 3'd0;
				mode_nx = (skip_nx != 3'd0) ? ecte_pkg::MODE_SKIP : ecte_pkg::MODE_NORMAL;
			end
			ecte_pkg::MODE_LITERAL: begin
				has_res = 1'b1;
			end
			ecte_pkg::MODE_CONTROL: begin
				if (s_tdata == ecte_pkg::CTRL_TAB) begin
					has_res = 1'b1;
					res0.kind = ecte_pkg::KIND_TAB;
					res0.char_value = ecte_pkg::CHAR_TAB;
				end else if (s_tdata == ecte_pkg::CTRL_SKIP2) begin
					skip_nx = 3'd2;
					mode_nx = ecte_pkg::MODE_SKIP;
				end else if (s_tdata == ecte_pkg::CTRL_SKIP6) begin
					skip_nx = 3'd6;
					mode_nx = ecte_pkg::MODE_SKIP;
				end else if (s_tdata != ecte_pkg::BYTE_NULL) begin
					has_res = 1'b1;
					res0.kind = ecte_pkg::KIND_BAD_CTRL;
				end
			end
			default: begin
				if (s_tdata == ecte_pkg::BYTE_NULL) begin
					has_res = 1'b1;
					res0.kind = ecte_pkg::KIND_NULL;
				end else if (s_tdata < ecte_pkg::BYTE_TOP) begin
					has_res = 1'b1;
				end else if (s_tdata inside
						{[ecte_pkg::CODE_SKIP2_LO:ecte_pkg::CODE_SKIP2_HI]}) begin
					skip_nx = 3'd2;
					mode_nx = ecte_pkg::MODE_SKIP;
				end else if (s_tdata inside
						{[ecte_pkg::CODE_SKIP1_LO:ecte_pkg::CODE_SKIP1_HI]}) begin
					skip_nx = 3'd1;
					mode_nx = ecte_pkg::MODE_SKIP;
				end else begin
					case (s_tdata)
						ecte_pkg::CODE_SKIP3: begin
							skip_nx = 3'd3;
							mode_nx = ecte_pkg::MODE_SKIP;
						end
						ecte_pkg::CODE_LITERAL: begin
							mode_nx = ecte_pkg::MODE_LITERAL;
						end
						ecte_pkg::CODE_SKIP2_A, ecte_pkg::CODE_SKIP2_B: begin
							skip_nx = 3'd2;
							mode_nx = ecte_pkg::MODE_SKIP;
						end
						ecte_pkg::CODE_CONTROL: begin
							mode_nx = ecte_pkg::MODE_CONTROL;
						end
						ecte_pkg::CODE_SKIP7: begin
							skip_nx = 3'd7;
							mode_nx = ecte_pkg::MODE_SKIP;
						end
						default: begin
							has_res = 1'b1;
							res0.kind = ecte_pkg::KIND_BAD_CODE;
						end
					endcase
				end
			end
		endcase
	end

	assign res_nl.kind = ecte_pkg::KIND_NEWLINE;
	assign res_nl.char_value = ecte_pkg::CHAR_NEWLINE;
	assign new_entry.first = has_res ? res0 : res_nl;
	assign new_entry.second = res_nl;
	assign new_entry.two = has_res && s_tlast;
	assign any_res = has_res || s_tlast;

	assign store = accept && any_res;
	assign pop = m_tvalid && m_tready;
	assign main_done = pop && m_tlast;
	assign main_free = !main_v_q || main_done;
	assign load_skid_main = main_free && skid_v_q;
	assign load_new_main = main_free && !skid_v_q && store;
	assign load_skid = store && !load_new_main;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= ecte_pkg::MODE_NORMAL;
			skip_q <= 3'd0;
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
			sel_q <= 1'b0;
		end else begin
			if (accept) begin
				// The end of a run drops whatever the code still owed.
				mode_q <= s_tlast ? ecte_pkg::MODE_NORMAL : mode_nx;
				skip_q <= s_tlast ? 3'd0 : skip_nx;
			end
			if (main_free) begin
				main_v_q <= skid_v_q || store;
				sel_q <= 1'b0;
			end else if (pop) begin
				sel_q <= 1'b1;
			end
			if (load_skid) begin
				skid_v_q <= 1'b1;
			end else if (load_skid_main) begin
				skid_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_skid_main) begin
			main_q <= skid_q;
		end else if (load_new_main) begin
			main_q <= new_entry;
		end
		if (load_skid) begin
			skid_q <= new_entry;
		end
	end

	assign s_tready = !skid_v_q;
	assign cur = sel_q ? main_q.second : main_q.first;
	assign m_tvalid = main_v_q;
	assign m_tdata = {5'd0, cur.char_value, cur.kind};
	assign m_tlast = !main_q.two || sel_q;

	`ASSERT_SAME(a_skid_behind_main, clk, arst_n, skid_v_q, main_v_q)
	`ASSERT_NEXT(a_second_follows, clk, arst_n, pop && !m_tlast, m_tvalid && m_tlast)
	`ASSERT_SAME(a_skip_count_mode, clk, arst_n, skip_q != 3'd0,
		mode_q == ecte_pkg::MODE_SKIP)
	`ASSERT_SAME(a_skip_mode_count, clk, arst_n, mode_q == ecte_pkg::MODE_SKIP,
		skip_q != 3'd0)

endmodule
